/* hdl/urde_pkg.sv */
// Shared types, codes and stream field widths for the UART register datagram engine.
// No dependencies; imported by the engine top level, urde_crc and urde_checker.
package urde_pkg;

  localparam int RX_CAPACITY_DEF = 16;
  localparam int FRAME_LEN       = 8;
  localparam int REQ_LEN         = 4;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_BAD_FRAME = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC   = 1'b0,
    CFG_MASTER = 1'b1
  } cfg_reg_e;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

/* hdl/uart_register_datagram_engine.sv */
// UART register datagram engine top level: sequencer, shared CRC unit, receive window RAM.
// Depends on urde_pkg, urde_crc, urde_ram.
//
// Channel | Direction | Contents
// s_axis  | in        | tuser: operation; tdata: node, register, write value, rx byte
// m_axis  | out       | tuser: kind; tdata: tx byte, read value, status; tlast: last
// cfg     | in        | we/idx/data: sync byte (0), master address (1)
//
// Write request: accepted, then 8 bytes, one per cycle while m_axis takes them.
// Read request: accepted, then 4 bytes. End of reply: accepted, then 1 report.
// Received byte: stored in the window RAM; with 8 or more bytes stored and no frame found yet,
// a scan walks the last 8 bytes through the RAM read port and the CRC unit.
// Reset: control state clears at once, no clearing pass. A stalled m_axis holds the sequencer.
module uart_register_datagram_engine #(
  parameter int RX_CAPACITY = urde_pkg::RX_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] node_address, [14:8] register_index, [46:15] write_value, [54:47] rx_byte
  input  logic [urde_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] operation
  input  logic [urde_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] tx_byte, [39:8] read_value, [41:40] status
  output logic [urde_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] kind
  output logic [urde_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_we_i,
  input  logic [urde_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [urde_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import urde_pkg::*;

  localparam int AW = $clog2(RX_CAPACITY);
  localparam int CW = $clog2(RX_CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TX,
    S_SCAN,
    S_REPORT
  } state_e;

  state_e          state_q;
  logic [7:0]      sync_q;
  logic [7:0]      master_q;
  logic [2:0]      idx_q;
  logic [2:0]      last_idx_q;
  logic [7:0]      crc_q;
  logic [7:0]      node_q;
  logic [7:0]      regb_q;
  logic [31:0]     value_q;
  logic [3:0]      sk_q;
  logic [AW-1:0]   base_q;
  logic            match_q;
  logic [31:0]     shift_q;
  logic [CW-1:0]   count_q;
  logic [6:0]      exp_reg_q;
  logic            found_q;
  logic [31:0]     captured_q;
  logic            m_valid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;
  logic            m_tuser_q;
  logic            m_tlast_q;

  op_e             in_op;
  logic [7:0]      in_node;
  logic [6:0]      in_reg;
  logic [31:0]     in_value;
  logic [7:0]      in_rx;
  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            has_room;
  logic [CW-1:0]   count_inc;
  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      tx_byte;
  logic [7:0]      crc_byte;
  logic [7:0]      crc_next;
  logic [2:0]      pos;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_node  = s_axis_tdata_i[7:0];
  assign in_reg   = s_axis_tdata_i[14:8];
  assign in_value = s_axis_tdata_i[46:15];
  assign in_rx    = s_axis_tdata_i[54:47];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign out_load  = out_free && ((state_q == S_TX) || (state_q == S_REPORT));
  assign has_room  = count_q < CW'(RX_CAPACITY);
  assign count_inc = count_q + CW'(1);
  assign ram_we    = accept && (in_op == OP_RX_BYTE) && has_room;
  assign ram_raddr = base_q + AW'(sk_q[2:0]);
  assign pos       = 3'(sk_q - 4'd1);

  always_comb begin
    unique case (idx_q)
      3'd0:    tx_byte = sync_q;
      3'd1:    tx_byte = node_q;
      3'd2:    tx_byte = regb_q;
      3'd3:    tx_byte = value_q[31:24];
      3'd4:    tx_byte = value_q[23:16];
      3'd5:    tx_byte = value_q[15:8];
      3'd6:    tx_byte = value_q[7:0];
      default: tx_byte = 8'd0;
    endcase
    if (idx_q == last_idx_q) begin
      tx_byte = crc_q;
    end
  end

  assign crc_byte = (state_q == S_TX) ? tx_byte : ram_rdata;

  urde_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (crc_byte),
    .crc_o  (crc_next)
  );

  urde_ram #(
    .WIDTH (8),
    .DEPTH (RX_CAPACITY)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_rx),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sync_q     <= 8'd5;
      master_q   <= 8'd255;
      idx_q      <= '0;
      last_idx_q <= '0;
      crc_q      <= '0;
      node_q     <= '0;
      regb_q     <= '0;
      value_q    <= '0;
      sk_q       <= '0;
      base_q     <= '0;
      match_q    <= 1'b0;
      shift_q    <= '0;
      count_q    <= '0;
      exp_reg_q  <= '0;
      found_q    <= 1'b0;
      captured_q <= '0;
      m_valid_q  <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= KIND_TX;
      m_tlast_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SYNC) begin
          sync_q <= cfg_data_i;
        end else begin
          master_q <= cfg_data_i;
        end
      end

      if (m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            crc_q <= '0;
            idx_q <= '0;
            unique case (in_op)
              OP_WRITE: begin
                node_q     <= in_node;
                regb_q     <= {1'b1, in_reg};
                value_q    <= in_value;
                last_idx_q <= 3'(FRAME_LEN - 1);
                state_q    <= S_TX;
              end
              OP_READ: begin
                node_q     <= in_node;
                regb_q     <= {1'b0, in_reg};
                last_idx_q <= 3'(REQ_LEN - 1);
                count_q    <= '0;
                found_q    <= 1'b0;
                captured_q <= '0;
                exp_reg_q  <= in_reg;
                state_q    <= S_TX;
              end
              OP_RX_BYTE: begin
                if (has_room) begin
                  count_q <= count_inc;
                  if (!found_q && count_inc >= CW'(FRAME_LEN)) begin
                    base_q  <= AW'(count_inc - CW'(FRAME_LEN));
                    sk_q    <= '0;
                    match_q <= 1'b1;
                    state_q <= S_SCAN;
                  end
                end
              end
              OP_END: begin
                state_q <= S_REPORT;
              end
            endcase
          end
        end
        S_TX: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_tuser_q <= KIND_TX;
            m_tdata_q <= {6'd0, ST_OK, 32'd0, tx_byte};
            m_tlast_q <= (idx_q == last_idx_q);
            crc_q     <= crc_next;
            idx_q     <= idx_q + 3'd1;
            if (idx_q == last_idx_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          sk_q <= sk_q + 4'd1;
          if (sk_q != 4'd0) begin
            unique case (pos)
              3'd0: if (ram_rdata != sync_q) match_q <= 1'b0;
              3'd1: if (ram_rdata != master_q) match_q <= 1'b0;
              3'd2: if (ram_rdata != {1'b0, exp_reg_q}) match_q <= 1'b0;
              3'd3, 3'd4, 3'd5, 3'd6: shift_q <= {shift_q[23:0], ram_rdata};
              default: begin
                if (match_q && ram_rdata == crc_q) begin
                  found_q    <= 1'b1;
                  captured_q <= shift_q;
                end
                state_q <= S_IDLE;
              end
            endcase
            if (pos != 3'd7) begin
              crc_q <= crc_next;
            end
          end
        end
        S_REPORT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_tuser_q <= KIND_REPORT;
            m_tlast_q <= 1'b1;
            priority if (count_q == '0) begin
              m_tdata_q <= {6'd0, ST_TIMEOUT, 32'd0, 8'd0};
            end else if (found_q) begin
              m_tdata_q <= {6'd0, ST_OK, captured_q, 8'd0};
            end else begin
              m_tdata_q <= {6'd0, ST_BAD_FRAME, 32'd0, 8'd0};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;
  assign m_axis_tlast_o  = m_tlast_q;

endmodule

/* hdl/urde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/urde_crc.sv */
// Byte-wide CRC8 step (poly 0x07, data LSB first), shared by transmit and window check.
// Depends on urde_pkg.
module urde_crc (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);
  import urde_pkg::*;

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    c = crc_i;
    d = byte_i;
    for (int b = 0; b < 8; b++) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {1'b0, d[7:1]};
    end
    crc_o = c;
  end

endmodule

/* hdl/urde_checker.sv */
// Port-level checks for uart_register_datagram_engine, attached by bind.
// Depends on urde_pkg.
module urde_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [urde_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [urde_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);
  import urde_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] == KIND_REPORT |-> m_axis_tlast_o)
    else $error("report transaction without tlast");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] == KIND_TX |-> m_axis_tdata_o[41:8] == '0)
    else $error("transmit transaction carries value or status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[41:40] != 2'd3)
    else $error("undefined status code");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[41:40] != ST_OK |-> m_axis_tdata_o[39:8] == '0)
    else $error("failed report carries a value");

endmodule

bind uart_register_datagram_engine urde_checker u_urde_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for uart_register_datagram_engine: directed table, then random phases.
// Depends on urde_pkg and the engine RTL; carries its own datagram predictor and result queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import urde_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [1:0] ROW_BYTE = 2'd0;
  localparam logic [1:0] ROW_FRAME = 2'd1;
  localparam logic [1:0] ROW_BADCRC = 2'd2;
  localparam int FLAW_NONE = 0;
  localparam int FLAW_SYNC = 1;
  localparam int FLAW_ADDR = 2;
  localparam int FLAW_REG = 3;
  localparam int FLAW_CRC = 4;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [31:0] value;
    status_e     status;
    logic        last;
  } dgram_res_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  mode;
    logic [7:0]  node;
    logic [7:0]  regb;
    logic [31:0] val;
    logic [7:0]  rxb;
    logic        typed;
    status_e     exp_st;
    logic [31:0] exp_val;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [IN_TUSER_W-1:0] s_tuser = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  uart_register_datagram_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // predictor state
  logic [7:0]  mdl_sync = 8'd5;
  logic [7:0]  mdl_master = 8'd255;
  logic [7:0]  rx_win[RX_CAPACITY_DEF];
  int          rx_cnt = 0;
  logic [6:0]  want_reg = '0;
  logic        frame_hit = 1'b0;
  logic [31:0] hit_value = '0;

  dgram_res_t fresh[$];
  dgram_res_t pending[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  dir_row_t dir_rows[12];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [7:0] crc8_atm(input octet_q_t bytes);
    logic [7:0] crc;
    logic [7:0] cur;
    logic fb;
    crc = 8'h00;
    foreach (bytes[i]) begin
      cur = bytes[i];
      for (int b = 0; b < 8; b++) begin
        fb = crc[7] ^ cur[0];
        crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        cur = cur >> 1;
      end
    end
    return crc;
  endfunction

  function automatic void emit_frame(input octet_q_t bytes);
    dgram_res_t r;
    bytes.push_back(crc8_atm(bytes));
    foreach (bytes[i]) begin
      r.kind = KIND_TX;
      r.tx = bytes[i];
      r.value = '0;
      r.status = ST_OK;
      r.last = (i == bytes.size() - 1);
      fresh.push_back(r);
    end
  endfunction

  // fills fresh with the results one transaction causes
  function automatic void predict_datagram(input op_e op, input logic [7:0] node,
                                           input logic [6:0] rg, input logic [31:0] val,
                                           input logic [7:0] rxb);
    octet_q_t fr;
    dgram_res_t r;
    fresh.delete();
    case (op)
      OP_WRITE: begin
        fr = '{mdl_sync, node, {1'b1, rg}, val[31:24], val[23:16], val[15:8], val[7:0]};
        emit_frame(fr);
      end
      OP_READ: begin
        rx_cnt = 0;
        frame_hit = 1'b0;
        hit_value = '0;
        want_reg = rg;
        fr = '{mdl_sync, node, {1'b0, rg}};
        emit_frame(fr);
      end
      OP_RX_BYTE: begin
        if (rx_cnt < RX_CAPACITY_DEF) begin
          rx_win[rx_cnt] = rxb;
          rx_cnt++;
          if (!frame_hit && rx_cnt >= FRAME_LEN) begin
            fr.delete();
            for (int i = rx_cnt - FRAME_LEN; i < rx_cnt - 1; i++) fr.push_back(rx_win[i]);
            if (fr[0] == mdl_sync && fr[1] == mdl_master && fr[2] == {1'b0, want_reg} &&
                crc8_atm(fr) == rx_win[rx_cnt-1]) begin
              frame_hit = 1'b1;
              hit_value = {fr[3], fr[4], fr[5], fr[6]};
            end
          end
        end
      end
      default: begin
        r.kind = KIND_REPORT;
        r.tx = '0;
        r.last = 1'b1;
        r.value = '0;
        if (rx_cnt == 0) r.status = ST_TIMEOUT;
        else if (frame_hit) begin
          r.status = ST_OK;
          r.value = hit_value;
        end else r.status = ST_BAD_FRAME;
        fresh.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // result sink: checks every transaction on m_axis and paces tready
  always @(posedge clk_i) begin : result_sink
    dgram_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual tdata %h kind %b last %b",
                 $time, m_tdata, m_tuser[0], m_tlast);
      end else begin
        want = pending.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
        check_field("tx_byte", 32'(want.tx), 32'(m_tdata[7:0]));
        check_field("read_value", want.value, m_tdata[39:8]);
        check_field("status", 32'(want.status), 32'(m_tdata[41:40]));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  task automatic send_txn(input op_e op, input logic [7:0] node, input logic [6:0] rg,
                          input logic [31:0] val, input logic [7:0] rxb,
                          input logic typed = 1'b0, input status_e exp_st = ST_OK,
                          input logic [31:0] exp_val = '0);
    dgram_res_t r;
    while (!calm && $urandom_range(99) < 22) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, rxb, val, rg, node};
    do @(posedge clk_i); while (!s_ready);
    predict_datagram(op, node, rg, val, rxb);
    if (typed) begin
      fresh.delete();
      r.kind = KIND_REPORT;
      r.tx = '0;
      r.value = exp_val;
      r.status = exp_st;
      r.last = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) pending.push_back(fresh[i]);
    items_sent++;
  endtask

  // sends an 8-byte reply frame built from the current settings, optionally spoiled
  task automatic send_reply(input logic [7:0] regb, input logic [31:0] val, input int flaw);
    octet_q_t fr;
    logic [7:0] spoil;
    fr = '{mdl_sync, mdl_master, regb, val[31:24], val[23:16], val[15:8], val[7:0]};
    fr.push_back(crc8_atm(fr));
    spoil = $urandom_range(1) ? 8'h80 : 8'($urandom_range(255, 1));
    case (flaw)
      FLAW_SYNC: fr[0] ^= spoil;
      FLAW_ADDR: fr[1] ^= spoil;
      FLAW_REG:  fr[2] ^= spoil;
      FLAW_CRC:  fr[7] ^= spoil;
      default: ;
    endcase
    foreach (fr[i]) send_txn(OP_RX_BYTE, 8'($urandom), 7'($urandom), $urandom, fr[i]);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC) mdl_sync = data;
    else mdl_master = data;
    @(posedge clk_i);
  endtask

  task automatic random_items(input int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_txn(OP_WRITE, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end else if (pick < 30) begin
        send_txn(OP_READ, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end else if (pick < 70) begin
        repeat ($urandom_range(3))
          send_txn(OP_RX_BYTE, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
        send_reply({1'b0, want_reg}, $urandom, FLAW_NONE);
        if ($urandom_range(99) < 60)
          send_txn(OP_END, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end else if (pick < 80) begin
        send_reply({1'b0, want_reg}, $urandom, $urandom_range(FLAW_CRC, FLAW_SYNC));
      end else if (pick < 90) begin
        send_txn(OP_END, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end else begin
        send_txn(OP_RX_BYTE, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end
    end
  endtask

  initial begin
    dir_rows = '{
      '{OP_END,     ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b1, ST_TIMEOUT,   32'h0},
      '{OP_RX_BYTE, ROW_BYTE,   8'hFF, 8'h7F, 32'hFFFF_FFFF, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_END,     ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b1, ST_BAD_FRAME, 32'h0},
      '{OP_WRITE,   ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'hFF, 1'b0, ST_OK,        32'h0},
      '{OP_WRITE,   ROW_BYTE,   8'hFF, 8'h7F, 32'hFFFF_FFFF, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_READ,    ROW_BYTE,   8'h5A, 8'h7F, 32'h0000_0000, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_RX_BYTE, ROW_FRAME,  8'h00, 8'h7F, 32'hDEAD_BEEF, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_END,     ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b1, ST_OK, 32'hDEAD_BEEF},
      '{OP_END,     ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b1, ST_OK, 32'hDEAD_BEEF},
      '{OP_READ,    ROW_BYTE,   8'hA5, 8'h11, 32'h0000_0000, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_RX_BYTE, ROW_BADCRC, 8'h00, 8'h11, 32'h1234_5678, 8'h00, 1'b0, ST_OK,        32'h0},
      '{OP_END,     ROW_BYTE,   8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b1, ST_BAD_FRAME, 32'h0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode == ROW_FRAME) begin
        send_reply(dir_rows[i].regb, dir_rows[i].val, FLAW_NONE);
      end else if (dir_rows[i].mode == ROW_BADCRC) begin
        send_reply(dir_rows[i].regb, dir_rows[i].val, FLAW_CRC);
      end else begin
        send_txn(dir_rows[i].op, dir_rows[i].node, dir_rows[i].regb[6:0], dir_rows[i].val,
                 dir_rows[i].rxb, dir_rows[i].typed, dir_rows[i].exp_st, dir_rows[i].exp_val);
      end
    end

    drain();
    write_cfg(CFG_SYNC, 8'h00);
    write_cfg(CFG_MASTER, 8'h00);
    hold_reqs <= hold_reqs + 1;
    random_items(62);

    drain();
    write_cfg(CFG_SYNC, 8'hFF);
    write_cfg(CFG_MASTER, 8'hFF);
    calm = 1'b1;
    random_items(62);
    calm = 1'b0;

    drain();
    write_cfg(CFG_SYNC, 8'($urandom));
    write_cfg(CFG_MASTER, 8'($urandom));
    random_items(62);

    drain();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
